FILE: rtl/utv_pkg.sv
// ----------------------------------------------------------------------------
// utv_pkg
// Shared types, constants and the whitespace classifier for the UTF-8
// validate-and-trim block.
// ----------------------------------------------------------------------------
package utv_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int FIELD_BITS  = 16;

    localparam logic [OFFSET_BITS-1:0] MAX_OFF = '1;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_BAD_LEAD,
        ERR_TRUNCATED,
        ERR_BAD_CONT,
        ERR_BAD_SCALAR,
        ERR_TOO_LONG
    } t_err;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [1:0]             bytes_pending;
        logic [20:0]            code_accum;
        logic [16:0]            least_allowed;
        logic [OFFSET_BITS-1:0] point_start;
        logic [OFFSET_BITS-1:0] first_kept;
        logic [OFFSET_BITS-1:0] end_kept;
        t_err                   error_latch;
    } t_state;

    typedef struct packed {
        t_err                  error_code;
        logic [FIELD_BITS-1:0] trimmed_start;
        logic [FIELD_BITS-1:0] trimmed_length;
        logic                  all_blank;
    } t_result;

    localparam t_state STATE_RESET = '{
        byte_offset:   '0,
        bytes_pending: '0,
        code_accum:    '0,
        least_allowed: '0,
        point_start:   '0,
        first_kept:    MAX_OFF,
        end_kept:      '0,
        error_latch:   ERR_OK
    };

    function automatic logic is_space(input logic [20:0] c);
        return (c >= 21'h00009 && c <= 21'h0000d) ||
               (c >= 21'h0001c && c <= 21'h00020) ||
               (c == 21'h00085) || (c == 21'h000a0) || (c == 21'h01680) ||
               (c >= 21'h02000 && c <= 21'h0200a) ||
               (c == 21'h02028) || (c == 21'h02029) || (c == 21'h0202f) ||
               (c == 21'h0205f) || (c == 21'h03000);
    endfunction

endpackage

FILE: rtl/utv_step.sv
// ----------------------------------------------------------------------------
// utv_step
// Decodes one byte against the running string state and computes the next
// state, plus the result when the byte closes the string.
// ----------------------------------------------------------------------------
module utv_step (
    input  utv_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output utv_pkg::t_state  o_next,
    output utv_pkg::t_result o_result
);
    import utv_pkg::*;

    t_state  s;
    t_result res;
    logic    fin;

    always_comb begin
        s   = i_state;
        fin = 1'b0;
        res = '{error_code: ERR_OK, trimmed_start: '0, trimmed_length: '0, all_blank: 1'b0};

        if (i_state.error_latch == ERR_OK) begin
            if (i_state.byte_offset == MAX_OFF) begin
                s.error_latch = ERR_TOO_LONG;
            end else begin
                s.byte_offset = i_state.byte_offset + 1'b1;
                if (i_state.bytes_pending == 2'd0) begin
                    s.point_start = i_state.byte_offset;
                    if (!i_byte[7]) begin
                        s.code_accum    = {13'd0, i_byte};
                        s.least_allowed = '0;
                        fin             = 1'b1;
                    end else if (i_byte >= 8'hc2 && i_byte <= 8'hdf) begin
                        s.code_accum    = {16'd0, i_byte[4:0]};
                        s.bytes_pending = 2'd1;
                        s.least_allowed = 17'h00080;
                    end else if (i_byte >= 8'he0 && i_byte <= 8'hef) begin
                        s.code_accum    = {17'd0, i_byte[3:0]};
                        s.bytes_pending = 2'd2;
                        s.least_allowed = 17'h00800;
                    end else if (i_byte >= 8'hf0 && i_byte <= 8'hf4) begin
                        s.code_accum    = {18'd0, i_byte[2:0]};
                        s.bytes_pending = 2'd3;
                        s.least_allowed = 17'h10000;
                    end else begin
                        s.error_latch = ERR_BAD_LEAD;
                    end
                end else if (i_byte[7:6] != 2'b10) begin
                    s.error_latch = ERR_BAD_CONT;
                end else begin
                    s.code_accum    = {i_state.code_accum[14:0], i_byte[5:0]};
                    s.bytes_pending = i_state.bytes_pending - 2'd1;
                    fin             = (i_state.bytes_pending == 2'd1);
                end
            end
        end

        if (fin) begin
            if ((s.code_accum < {4'd0, s.least_allowed}) || (s.code_accum > 21'h10ffff) ||
                (s.code_accum >= 21'h0d800 && s.code_accum <= 21'h0dfff)) begin
                s.error_latch = ERR_BAD_SCALAR;
            end else if (!is_space(s.code_accum)) begin
                if (s.first_kept == MAX_OFF) begin
                    s.first_kept = s.point_start;
                end
                s.end_kept = s.byte_offset;
            end
        end

        if (i_last) begin
            if (s.error_latch == ERR_OK && s.bytes_pending != 2'd0) begin
                s.error_latch = ERR_TRUNCATED;
            end
            res.error_code = s.error_latch;
            if (s.error_latch == ERR_OK) begin
                if (s.first_kept == MAX_OFF) begin
                    res.all_blank = 1'b1;
                end else begin
                    res.trimmed_start  = FIELD_BITS'(s.first_kept);
                    res.trimmed_length = FIELD_BITS'(s.end_kept - s.first_kept);
                end
            end
            o_next = STATE_RESET;
        end else begin
            o_next = s;
        end
        o_result = res;
    end

endmodule

FILE: rtl/utf8_validate_trim_top.sv
// The final byte of a string passes the input register and the decode step into
// the result register. Throughput: one byte per cycle, set by the decode step that
// updates the string state, save that a final byte waits while a result is untaken.
// Reset: synchronous, active low; clears the string state and both beat valid flags.
// ----------------------------------------------------------------------------
// utf8_validate_trim_top
// Strict UTF-8 validation of a byte string with whitespace trimming. An input
// register feeds the decode step; a result register holds the final beat.
// ----------------------------------------------------------------------------
module utf8_validate_trim_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_error_code,
    output logic [utv_pkg::FIELD_BITS-1:0]    o_trimmed_start,
    output logic [utv_pkg::FIELD_BITS-1:0]    o_trimmed_length,
    output logic                              o_all_blank
);
    import utv_pkg::*;

    logic    r_in_valid;
    logic [7:0] r_in_byte;
    logic    r_in_last;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    w_adv;
    logic    w_out_load;

    utv_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_next   (n_state),
        .o_result (n_result)
    );

    assign w_adv      = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign w_out_load = w_adv && r_in_last;
    assign o_ready    = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_state <= n_state;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (w_out_load) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_error_code     = r_result.error_code;
    assign o_trimmed_start  = r_result.trimmed_start;
    assign o_trimmed_length = r_result.trimmed_length;
    assign o_all_blank      = r_result.all_blank;

`ifndef SYNTHESIS
    a_err_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_OK |->
            o_trimmed_start == '0 && o_trimmed_length == '0 && !o_all_blank)
        else $error("error result carries nonzero trim fields");

    a_blank_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_all_blank |-> o_error_code == ERR_OK && o_trimmed_length == '0)
        else $error("blank result with error or length");

    a_state_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> r_state.byte_offset == '0 && r_state.error_latch == ERR_OK &&
            r_state.first_kept == MAX_OFF && r_out_valid)
        else $error("string state not rearmed after final beat");

    a_error_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.error_latch != ERR_OK && !w_out_load |=> $stable(r_state.byte_offset))
        else $error("offset advanced after an error was latched");
`endif

endmodule

FILE: bench/utf8_validate_trim_tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 validate-and-trim block. A driver feeds
// strings one beat per byte, a decoder model inside the bench predicts the
// verdict of every string, and a monitor compares each result beat with it.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utv_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned HOLD_AT      = 40;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned RANDOM_BYTES = 1100;
    localparam int unsigned TAIL_BYTES   = 200;

    typedef struct packed {
        logic       steady;
        logic       fin;
        logic [7:0] octet;
    } t_byte_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  i_last_byte = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [2:0]            o_error_code;
    logic [FIELD_BITS-1:0] o_trimmed_start;
    logic [FIELD_BITS-1:0] o_trimmed_length;
    logic                  o_all_blank;

    t_byte_item  byte_backlog[$];
    logic [7:0]  text_buf[$];
    t_result     expected_verdicts[$];

    logic [OFFSET_BITS-1:0] str_pos;
    logic [1:0]             cont_left;
    logic [20:0]            cp_acc;
    logic [20:0]            cp_floor;
    logic [OFFSET_BITS-1:0] cp_begin;
    logic [OFFSET_BITS-1:0] keep_first;
    logic [OFFSET_BITS-1:0] keep_end;
    t_err                   err_seen;

    int unsigned beats_in = 0;
    int unsigned quiet_from = 0;
    int unsigned send_gap = 0;
    int unsigned send_idle_pct = 0;
    int unsigned take_stall = 0;
    int unsigned take_idle_pct = 0;
    int unsigned hold_left = 0;
    int unsigned verdicts_out = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    t_byte_item  next_item;
    t_result     want;

    utf8_validate_trim_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_error_code     (o_error_code),
        .o_trimmed_start  (o_trimmed_start),
        .o_trimmed_length (o_trimmed_length),
        .o_all_blank      (o_all_blank)
    );

    function automatic void put_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic logic is_blank_point(input logic [20:0] cp);
        return cp inside {[21'h00009:21'h0000d], [21'h0001c:21'h00020], 21'h00085,
                          21'h000a0, 21'h01680, [21'h02000:21'h0200a], 21'h02028,
                          21'h02029, 21'h0202f, 21'h0205f, 21'h03000};
    endfunction

    function automatic void clear_decoder();
        str_pos    = '0;
        cont_left  = 2'd0;
        cp_acc     = '0;
        cp_floor   = '0;
        cp_begin   = '0;
        keep_first = MAX_OFF;
        keep_end   = '0;
        err_seen   = ERR_OK;
    endfunction

    function automatic void close_point();
        if (cp_acc < cp_floor || cp_acc > 21'h10ffff ||
            (cp_acc >= 21'h0d800 && cp_acc <= 21'h0dfff)) begin
            err_seen = ERR_BAD_SCALAR;
        end else if (!is_blank_point(cp_acc)) begin
            if (keep_first == MAX_OFF) begin
                keep_first = cp_begin;
            end
            keep_end = str_pos;
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic fin);
        t_result verdict;
        if (err_seen == ERR_OK) begin
            if (str_pos == MAX_OFF) begin
                err_seen = ERR_TOO_LONG;
            end else if (cont_left == 2'd0) begin
                cp_begin = str_pos;
                str_pos  = str_pos + 16'd1;
                if (b < 8'h80) begin
                    cp_acc   = {13'b0, b};
                    cp_floor = 21'h0;
                    close_point();
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    cp_acc    = {16'b0, b[4:0]};
                    cont_left = 2'd1;
                    cp_floor  = 21'h00080;
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    cp_acc    = {17'b0, b[3:0]};
                    cont_left = 2'd2;
                    cp_floor  = 21'h00800;
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    cp_acc    = {18'b0, b[2:0]};
                    cont_left = 2'd3;
                    cp_floor  = 21'h10000;
                end else begin
                    err_seen = ERR_BAD_LEAD;
                end
            end else begin
                str_pos = str_pos + 16'd1;
                if (b[7:6] != 2'b10) begin
                    err_seen = ERR_BAD_CONT;
                end else begin
                    cp_acc    = {cp_acc[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        close_point();
                    end
                end
            end
        end
        if (fin) begin
            if (err_seen == ERR_OK && cont_left != 2'd0) begin
                err_seen = ERR_TRUNCATED;
            end
            verdict.error_code     = err_seen;
            verdict.trimmed_start  = '0;
            verdict.trimmed_length = '0;
            verdict.all_blank      = 1'b0;
            if (err_seen == ERR_OK) begin
                if (keep_first == MAX_OFF) begin
                    verdict.all_blank = 1'b1;
                end else begin
                    verdict.trimmed_start  = keep_first;
                    verdict.trimmed_length = keep_end - keep_first;
                end
            end
            expected_verdicts.insert(expected_verdicts.size(), verdict);
            clear_decoder();
        end
    endfunction

    function automatic int natural_size(input logic [20:0] cp);
        if (cp < 21'h00080) return 1;
        if (cp < 21'h00800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    function automatic void add_point(input logic [20:0] cp, input int nb);
        case (nb)
            1: begin
                put_byte({1'b0, cp[6:0]});
            end
            2: begin
                put_byte({3'b110, cp[10:6]});
                put_byte({2'b10, cp[5:0]});
            end
            3: begin
                put_byte({4'b1110, cp[15:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end
            default: begin
                put_byte({5'b11110, cp[20:18]});
                put_byte({2'b10, cp[17:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic logic [20:0] pick_blank();
        logic [20:0] cp;
        case ($urandom_range(5))
            0: cp = 21'h00009 + 21'($urandom_range(4));
            1: cp = 21'h0001c + 21'($urandom_range(4));
            2: cp = 21'h02000 + 21'($urandom_range(10));
            3: begin
                case ($urandom_range(2))
                    0: cp = 21'h00085;
                    1: cp = 21'h000a0;
                    default: cp = 21'h01680;
                endcase
            end
            4: begin
                case ($urandom_range(4))
                    0: cp = 21'h02028;
                    1: cp = 21'h02029;
                    2: cp = 21'h0202f;
                    3: cp = 21'h0205f;
                    default: cp = 21'h03000;
                endcase
            end
            default: cp = 21'h00020;
        endcase
        return cp;
    endfunction

    function automatic logic [20:0] pick_point();
        logic [20:0] cp;
        case ($urandom_range(9))
            0, 1, 2: cp = 21'($urandom_range(0, 127));
            3, 4: cp = pick_blank();
            5: cp = 21'($urandom_range(32'h80, 32'h7ff));
            6: begin
                cp = 21'($urandom_range(32'h800, 32'hffff));
                if (cp >= 21'h0d800 && cp <= 21'h0dfff) begin
                    cp = cp ^ 21'h04000;
                end
            end
            7: cp = 21'($urandom_range(32'h10000, 32'h10ffff));
            8: begin
                case ($urandom_range(8))
                    0: cp = 21'h0007f;
                    1: cp = 21'h00080;
                    2: cp = 21'h007ff;
                    3: cp = 21'h00800;
                    4: cp = 21'h0d7ff;
                    5: cp = 21'h0e000;
                    6: cp = 21'h0ffff;
                    7: cp = 21'h10000;
                    default: cp = 21'h10ffff;
                endcase
            end
            default: cp = 21'h00041 + 21'($urandom_range(25));
        endcase
        return cp;
    endfunction

    function automatic void add_fault();
        logic [7:0]  lead;
        logic [20:0] cp;
        int          nb;
        int          k;
        case ($urandom_range(3))
            0: begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++) begin
                    put_byte(8'($urandom_range(255)));
                end
            end
            1: begin
                put_byte({2'b10, 6'($urandom_range(63))});
            end
            2: begin
                lead = 8'($urandom_range(8'hc2, 8'hf4));
                nb = (lead >= 8'hf0) ? 3 : (lead >= 8'he0) ? 2 : 1;
                put_byte(lead);
                k = $urandom_range(0, nb - 1);
                for (int i = 0; i < k; i++) begin
                    put_byte({2'b10, 6'($urandom_range(63))});
                end
            end
            default: begin
                case ($urandom_range(2))
                    0: begin
                        nb = $urandom_range(2, 4);
                        cp = 21'($urandom_range(0, (nb == 2) ? 32'h7f :
                                                   (nb == 3) ? 32'h7ff : 32'hffff));
                    end
                    1: begin
                        nb = 3;
                        cp = 21'($urandom_range(32'hd800, 32'hdfff));
                    end
                    default: begin
                        nb = 4;
                        cp = 21'($urandom_range(32'h110000, 32'h13ffff));
                    end
                endcase
                add_point(cp, nb);
            end
        endcase
    endfunction

    function automatic void flush_text(input logic steady);
        t_byte_item item;
        for (int i = 0; i < text_buf.size(); i++) begin
            item.steady = steady;
            item.fin    = (i == text_buf.size() - 1);
            item.octet  = text_buf[i];
            byte_backlog.insert(byte_backlog.size(), item);
        end
        text_buf.delete();
    endfunction

    function automatic void gen_text();
        int          kind;
        int          n;
        int          cut;
        logic [20:0] cp;
        kind = $urandom_range(99);
        n    = $urandom_range(1, 10);
        cut  = $urandom_range(0, n);
        for (int i = 0; i <= n; i++) begin
            if (kind >= 78 && i == cut) begin
                add_fault();
            end
            if (i < n) begin
                cp = (kind < 15) ? pick_blank() : pick_point();
                add_point(cp, natural_size(cp));
            end
        end
        flush_text(1'b0);
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 25;
            default: return 50;
        endcase
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sender: one beat per byte, gaps only between beats and never while a
    // beat is waiting to be taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                absorb_byte(i_data_byte, i_last_byte);
                beats_in <= beats_in + 1;
                if (beats_in % 64 == 63) begin
                    send_idle_pct = pick_idle_pct();
                end
            end
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    send_gap = send_gap - 1;
                    i_valid <= 1'b0;
                end else if (byte_backlog.size() != 0) begin
                    next_item = byte_backlog.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= next_item.octet;
                    i_last_byte <= next_item.fin;
                    if (!next_item.steady && beats_in < quiet_from &&
                        $urandom_range(99) < send_idle_pct) begin
                        send_gap = $urandom_range(1, 19);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every result beat and applies random stalls plus one
    // long hold-off that backs the block up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                verdicts_out = verdicts_out + 1;
                if (verdicts_out % 16 == 0) begin
                    take_idle_pct = pick_idle_pct();
                end
                if (expected_verdicts.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10) begin
                        $display("unexpected result beat: err %0d start %0d len %0d blank %0b",
                                 o_error_code, o_trimmed_start, o_trimmed_length,
                                 o_all_blank);
                    end
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_error_code !== want.error_code ||
                        o_trimmed_start !== want.trimmed_start ||
                        o_trimmed_length !== want.trimmed_length ||
                        o_all_blank !== want.all_blank) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10) begin
                            $display("result %0d: expected err %0d start %0d len %0d blank %0b",
                                     verdicts_out, want.error_code, want.trimmed_start,
                                     want.trimmed_length, want.all_blank);
                            $display("result %0d: got      err %0d start %0d len %0d blank %0b",
                                     verdicts_out, o_error_code, o_trimmed_start,
                                     o_trimmed_length, o_all_blank);
                        end
                    end
                end
                if (verdicts_out == HOLD_AT) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else if (take_stall != 0) begin
                take_stall = take_stall - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (beats_in < quiet_from && $urandom_range(99) < take_idle_pct) begin
                    take_stall = $urandom_range(1, 19);
                end
            end
        end
    end

    initial begin
        int unsigned target;
        clear_decoder();
        send_idle_pct = pick_idle_pct();
        take_idle_pct = pick_idle_pct();

        put_byte(8'h00); flush_text(1'b0);
        put_byte(8'hff); flush_text(1'b0);
        put_byte(8'h20); put_byte(8'h41);
        put_byte(8'h7f); put_byte(8'h09); flush_text(1'b0);
        add_point(21'h00085, 2); add_point(21'h03000, 3); flush_text(1'b0);
        put_byte(8'hc0); put_byte(8'h80); flush_text(1'b0);
        put_byte(8'hc2); put_byte(8'h41); flush_text(1'b0);
        add_point(21'h0d800, 3); flush_text(1'b0);
        add_point(21'h110000, 4); flush_text(1'b0);
        add_point(21'h0007f, 3); flush_text(1'b0);
        put_byte(8'hf0); put_byte(8'h9f); flush_text(1'b0);

        target = byte_backlog.size() + RANDOM_BYTES;
        while (byte_backlog.size() < target) begin
            gen_text();
        end

        quiet_from = byte_backlog.size();
        target = quiet_from + TAIL_BYTES;
        while (byte_backlog.size() < target) begin
            gen_text();
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_backlog.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/utv_pkg.sv
rtl/utv_step.sv
rtl/utf8_validate_trim_top.sv
bench/utf8_validate_trim_tb.sv
